// ===== hdl/rctm_pkg.sv =====
// ---------------------------------------------------------------------------
// rctm_pkg: shared types and constants of the rc time constant meter
// Word layouts, command codes, register indexes and internal operation codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rctm_pkg;

   // fixed field widths
   localparam int SAMPLE_W  = 12;
   localparam int TICK_W    = 16;
   localparam int TAU_OUT_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // command codes carried by a command word
   localparam logic [2:0] CMD_ENABLE       = 3'd1;
   localparam logic [2:0] CMD_CHARGE       = 3'd2;
   localparam logic [2:0] CMD_DISCHARGE    = 3'd3;
   localparam logic [2:0] CMD_ARM_RECHARGE = 3'd4;
   localparam logic [2:0] CMD_ARM_DISCHRG  = 3'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP       = 3'd5;

   // register reset values
   localparam logic [SAMPLE_W-1:0] EMPTY_RST      = 12'd112;
   localparam logic [SAMPLE_W-1:0] FULL_RST       = 12'd3972;
   localparam logic [SAMPLE_W-1:0] FULL_START_RST = 12'd3948;
   localparam logic [SAMPLE_W-1:0] RISE_RST       = 12'd2581;
   localparam logic [SAMPLE_W-1:0] FALL_RST       = 12'd1515;
   localparam logic [TICK_W-1:0]   WRAP_RST       = 16'd30000;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // input word
   typedef struct packed {
      logic                mode;
      logic [2:0]          command;
      logic [SAMPLE_W-1:0] sample;
      logic [TICK_W-1:0]   elapsed_ticks;
   } req_type;

   // result word
   typedef struct packed {
      logic                 charge_drive;
      logic                 sample_valid;
      logic [SAMPLE_W-1:0]  sample_echo;
      logic                 tau_valid;
      logic [TAU_OUT_W-1:0] tau_ms;
      logic                 timing_active;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [SAMPLE_W-1:0] empty_code;
      logic [SAMPLE_W-1:0] full_code;
      logic [SAMPLE_W-1:0] full_start_code;
      logic [SAMPLE_W-1:0] rise_code;
      logic [SAMPLE_W-1:0] fall_code;
      logic [TICK_W-1:0]   wrap_ticks;
   } cfg_type;

   // classified operation
   typedef enum logic [2:0] {
      OP_NONE,
      OP_SAMPLE,
      OP_ENABLE,
      OP_CHARGE,
      OP_DISCHARGE,
      OP_ARM_RECHARGE,
      OP_ARM_DISCHRG
   } op_kind_type;

   typedef struct packed {
      op_kind_type         kind;
      logic [SAMPLE_W-1:0] sample;
      logic [TICK_W-1:0]   elapsed_ticks;
   } op_type;

   // direction of the charge pin
   typedef enum logic [1:0] {
      DIR_NONE      = 2'd0,
      DIR_CHARGE    = 2'd1,
      DIR_DISCHARGE = 2'd2
   } dir_type;

   // queue status toward front and back
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== hdl/rc_time_constant_meter.sv =====
// ---------------------------------------------------------------------------
// rc_time_constant_meter: rc time constant meter
// Drives the capacitor charge pin and times the rc constant from adc samples.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one word per command or adc sample (req_valid / req_stall).
//   rsp channel: exactly one result word per accepted word, in order
//   (rsp_valid / rsp_stall), carrying pin level, sample echo, tau and status.
//   csr port: csr_wr_en writes csr_wdata into register csr_index at once;
//   write only while no word is in flight.
//   The accepted word passes through a queue entry and then the output register before its result is on rsp.
//   Throughput: one word per cycle while rsp_stall is low; the back end updates all
//   meter state together, with a single saturating accumulate for tau.
//   A two-entry queue sits between classifier and back end, so req keeps
//   flowing while a result waits in the output register; under a long
//   rsp_stall the queue fills and req_stall rises.
//   Reset (synchronous): thresholds return to their defaults, sampling off,
//   no arm, no direction, timing off, pin low, counts cleared, queue empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_time_constant_meter #(
   parameter int ADC_BITS = 12,
   parameter int TAU_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rctm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rctm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [rctm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rctm_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   rctm_pkg::cfg_type          cfg_ff, cfg_in;
   rctm_pkg::op_type           front_op, head_op;
   rctm_pkg::queue_status_type q_status;
   logic                       pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rctm_pkg::CSR_EMPTY:      cfg_in.empty_code      = csr_wdata[11:0];
            rctm_pkg::CSR_FULL:       cfg_in.full_code       = csr_wdata[11:0];
            rctm_pkg::CSR_FULL_START: cfg_in.full_start_code = csr_wdata[11:0];
            rctm_pkg::CSR_RISE:       cfg_in.rise_code       = csr_wdata[11:0];
            rctm_pkg::CSR_FALL:       cfg_in.fall_code       = csr_wdata[11:0];
            rctm_pkg::CSR_WRAP:       cfg_in.wrap_ticks      = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.empty_code      <= rctm_pkg::EMPTY_RST;
         cfg_ff.full_code       <= rctm_pkg::FULL_RST;
         cfg_ff.full_start_code <= rctm_pkg::FULL_START_RST;
         cfg_ff.rise_code       <= rctm_pkg::RISE_RST;
         cfg_ff.fall_code       <= rctm_pkg::FALL_RST;
         cfg_ff.wrap_ticks      <= rctm_pkg::WRAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify incoming words
   rctm_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .req_i (req_data),
      .op_o  (front_op)
   );

   assign req_stall = q_status.full;

   // queue between front and back
   rctm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_i    (req_valid),
      .push_op_i (front_op),
      .pop_i     (pop),
      .head_op_o (head_op),
      .status_o  (q_status)
   );

   // back: execute and register the result word
   rctm_back #(
      .TAU_BITS (TAU_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg_ff),
      .op_i       (head_op),
      .op_valid_i (!q_status.empty),
      .op_pop_o   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hdl/rctm_front.sv =====
// ---------------------------------------------------------------------------
// rctm_front: input classifier
// Decodes an input word into an operation and masks the sample to the adc width.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rctm_front #(
   parameter int ADC_BITS = 12
) (
   input  rctm_pkg::req_type req_i,
   output rctm_pkg::op_type  op_o
);

   localparam int MaskBits = (ADC_BITS < rctm_pkg::SAMPLE_W) ? ADC_BITS : rctm_pkg::SAMPLE_W;
   localparam logic [rctm_pkg::SAMPLE_W:0] MaskWide =
      ((rctm_pkg::SAMPLE_W+1)'(1) << MaskBits) - (rctm_pkg::SAMPLE_W+1)'(1);
   localparam logic [rctm_pkg::SAMPLE_W-1:0] AdcMask = MaskWide[rctm_pkg::SAMPLE_W-1:0];

   // operation decode
   always_comb begin
      op_o.sample        = req_i.sample & AdcMask;
      op_o.elapsed_ticks = req_i.elapsed_ticks;
      if (req_i.mode) begin
         op_o.kind = rctm_pkg::OP_SAMPLE;
      end else begin
         case (req_i.command)
            rctm_pkg::CMD_ENABLE:       op_o.kind = rctm_pkg::OP_ENABLE;
            rctm_pkg::CMD_CHARGE:       op_o.kind = rctm_pkg::OP_CHARGE;
            rctm_pkg::CMD_DISCHARGE:    op_o.kind = rctm_pkg::OP_DISCHARGE;
            rctm_pkg::CMD_ARM_RECHARGE: op_o.kind = rctm_pkg::OP_ARM_RECHARGE;
            rctm_pkg::CMD_ARM_DISCHRG:  op_o.kind = rctm_pkg::OP_ARM_DISCHRG;
            default:                    op_o.kind = rctm_pkg::OP_NONE;
         endcase
      end
   end

endmodule

// ===== hdl/rctm_queue.sv =====
// ---------------------------------------------------------------------------
// rctm_queue: operation queue
// Short fifo between the classifier and the execution back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rctm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_i,
   input  rctm_pkg::op_type           push_op_i,
   input  logic                       pop_i,
   output rctm_pkg::op_type           head_op_o,
   output rctm_pkg::queue_status_type status_o
);

   localparam int PtrW = $clog2(rctm_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(rctm_pkg::QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(rctm_pkg::QUEUE_DEPTH);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(rctm_pkg::QUEUE_DEPTH - 1);

   rctm_pkg::op_type entry_ff [rctm_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   // status
   assign status_o.empty = (count_ff == '0);
   assign status_o.full  = (count_ff == DepthCnt);
   assign do_push = push_i && !status_o.full;
   assign do_pop  = pop_i && !status_o.empty;
   assign head_op_o = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op_i;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue count beyond depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

// ===== hdl/rctm_back.sv =====
// ---------------------------------------------------------------------------
// rctm_back: measurement back end
// Executes one op a cycle on meter state unless stalled and registers the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rctm_back #(
   parameter int TAU_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  rctm_pkg::cfg_type cfg_i,
   input  rctm_pkg::op_type  op_i,
   input  logic              op_valid_i,
   output logic              op_pop_o,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rctm_pkg::rsp_type rsp_data
);

   localparam int TickW = rctm_pkg::TICK_W;
   localparam int OutW  = rctm_pkg::TAU_OUT_W;

   // meter state
   logic                  sampling_on_ff, sampling_on_in;
   logic                  arm_recharge_ff, arm_recharge_in;
   logic                  arm_discharge_ff, arm_discharge_in;
   rctm_pkg::dir_type     dir_ff, dir_in;
   logic                  timing_ff, timing_in;
   logic                  pin_ff, pin_in;
   logic [TickW-1:0]      tick_ff, tick_in;
   logic [TAU_BITS-1:0]   tau_ff, tau_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rctm_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // datapath
   logic                  load;
   logic [TickW:0]        tick_sum;
   logic [TickW-1:0]      tick_sat;
   logic                  wrap, start, finish, is_sample;
   logic [TAU_BITS-1:0]   addend;
   logic [TAU_BITS:0]     tau_sum_wide;
   logic [TAU_BITS-1:0]   tau_sat;
   logic [TAU_BITS+OutW-1:0] tau_ext;

   assign load     = !rsp_valid_ff || !rsp_stall;
   assign op_pop_o = op_valid_i && load;

   // saturating tick count and fold on wrap
   assign tick_sum = {1'b0, tick_ff} + {1'b0, op_i.elapsed_ticks};
   assign tick_sat = tick_sum[TickW] ? '1 : tick_sum[TickW-1:0];
   assign wrap     = timing_ff && (tick_sat >= cfg_i.wrap_ticks);

   // single saturating accumulate serves both the fold and the finish
   assign addend       = TAU_BITS'(tick_sat >> 1);
   assign tau_sum_wide = {1'b0, tau_ff} + {1'b0, ((wrap || finish) ? addend : '0)};
   assign tau_sat      = tau_sum_wide[TAU_BITS] ? '1 : tau_sum_wide[TAU_BITS-1:0];
   assign tau_ext      = {{OutW{1'b0}}, tau_sat};

   // tau restarts on a timing start, otherwise takes the accumulate on samples
   assign tau_in = !is_sample ? tau_ff : (start ? '0 : tau_sat);

   // next state per operation
   always_comb begin
      sampling_on_in   = sampling_on_ff;
      arm_recharge_in  = arm_recharge_ff;
      arm_discharge_in = arm_discharge_ff;
      dir_in           = dir_ff;
      timing_in        = timing_ff;
      pin_in           = pin_ff;
      tick_in          = tick_ff;
      start            = 1'b0;
      finish           = 1'b0;
      is_sample        = 1'b0;
      case (op_i.kind)
         rctm_pkg::OP_ENABLE: begin
            sampling_on_in = 1'b1;
         end
         rctm_pkg::OP_CHARGE: begin
            dir_in = rctm_pkg::DIR_CHARGE;
            pin_in = 1'b1;
         end
         rctm_pkg::OP_DISCHARGE: begin
            dir_in = rctm_pkg::DIR_DISCHARGE;
            pin_in = 1'b0;
         end
         rctm_pkg::OP_ARM_RECHARGE: begin
            arm_recharge_in = 1'b1;
            pin_in          = 1'b0;
         end
         rctm_pkg::OP_ARM_DISCHRG: begin
            arm_discharge_in = 1'b1;
            pin_in           = 1'b1;
         end
         rctm_pkg::OP_SAMPLE: begin
            if (sampling_on_ff) begin
               is_sample = 1'b1;
               // armed auto-switch, recharge arm first
               if (arm_recharge_ff) begin
                  if (op_i.sample < cfg_i.empty_code) begin
                     arm_recharge_in = 1'b0;
                     pin_in          = 1'b1;
                     dir_in          = rctm_pkg::DIR_CHARGE;
                  end
               end else if (arm_discharge_ff) begin
                  if (op_i.sample >= cfg_i.full_code) begin
                     arm_discharge_in = 1'b0;
                     pin_in           = 1'b0;
                     dir_in           = rctm_pkg::DIR_DISCHARGE;
                  end
               end
               // timing start and end
               start = ((op_i.sample < cfg_i.empty_code) && (dir_in == rctm_pkg::DIR_CHARGE))
                    || ((op_i.sample >= cfg_i.full_start_code)
                        && (dir_in == rctm_pkg::DIR_DISCHARGE));
               finish = !start && timing_ff
                    && (((op_i.sample >= cfg_i.rise_code) && (dir_in == rctm_pkg::DIR_CHARGE))
                     || ((op_i.sample <= cfg_i.fall_code)
                         && (dir_in == rctm_pkg::DIR_DISCHARGE)));
               tick_in = (start || wrap) ? '0 : tick_sat;
               if (start) begin
                  timing_in = 1'b1;
               end else if (finish) begin
                  timing_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in               = op_valid_i;
         rsp_data_in.charge_drive   = pin_in;
         rsp_data_in.sample_valid   = is_sample;
         rsp_data_in.sample_echo    = is_sample ? op_i.sample : '0;
         rsp_data_in.tau_valid      = finish;
         rsp_data_in.tau_ms         = finish ? tau_ext[OutW-1:0] : '0;
         rsp_data_in.timing_active  = timing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampling_on_ff   <= 1'b0;
         arm_recharge_ff  <= 1'b0;
         arm_discharge_ff <= 1'b0;
         dir_ff           <= rctm_pkg::DIR_NONE;
         timing_ff        <= 1'b0;
         pin_ff           <= 1'b0;
         tick_ff          <= '0;
         tau_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (op_pop_o) begin
            sampling_on_ff   <= sampling_on_in;
            arm_recharge_ff  <= arm_recharge_in;
            arm_discharge_ff <= arm_discharge_in;
            dir_ff           <= dir_in;
            timing_ff        <= timing_in;
            pin_ff           <= pin_in;
            tick_ff          <= tick_in;
            tau_ff           <= tau_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_tau_ends_timing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.tau_valid)
         |-> (rsp_data_ff.sample_valid && !rsp_data_ff.timing_active))
      else $error("finished measurement still timing or not a sample");

   a_timing_needs_enable: assert property (@(posedge clock) disable iff (reset)
      !sampling_on_ff |-> !timing_ff)
      else $error("timing without sampling enabled");

   a_timing_needs_dir: assert property (@(posedge clock) disable iff (reset)
      (dir_ff == rctm_pkg::DIR_NONE) |-> !timing_ff)
      else $error("timing with no charge direction");

endmodule
